@@ design/rmmit_pkg.sv @@
package rmmit_pkg;

  localparam int unsigned MAX_ELEMENTS = 1024;
  localparam int unsigned NODE_COUNT   = 2 * MAX_ELEMENTS;
  localparam int unsigned IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int unsigned NODE_W       = $clog2(NODE_COUNT);
  localparam int unsigned CNT_W        = IDX_W + 1;
  localparam int unsigned SPAN_W       = NODE_W + 1;
  localparam int unsigned VAL_W        = 32;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_SWAP  = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_LEAF_WR,
    ST_UP_RD,
    ST_UP_WR,
    ST_SW_RD,
    ST_SW_CAP,
    ST_SW_NEXT,
    ST_RD_RD,
    ST_RD_CAP,
    ST_Q_RD,
    ST_Q_CMB,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic [IDX_W-1:0]        pos;
    logic                    vld;
  } ent_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] mnv;
    logic [IDX_W-1:0]        mnp;
    logic signed [VAL_W-1:0] mxv;
    logic [IDX_W-1:0]        mxp;
    logic                    vld;
  } node_t;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] min_value;
    logic [IDX_W-1:0]        min_position;
    logic signed [VAL_W-1:0] max_value;
    logic [IDX_W-1:0]        max_position;
    logic                    ignored;
  } res_t;

  typedef struct packed {
    logic load;
    logic clr;
    logic leaf_wr;
    logic up_rd;
    logic up_wr;
    logic sw_rd;
    logic sw_cap;
    logic sw_next;
    logic rd_rd;
    logic rd_cap;
    logic q_init;
    logic q_rd;
    logic q_cmb;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic clr_busy;
    op_e  op;
    logic bad_write;
    logic bad_swap;
    logic q_empty;
    logic k_root;
    logic second;
    logic q_more;
  } sts_t;

  function automatic ent_t pick_min(ent_t a, ent_t b);
    ent_t r;
    if (!b.vld) r = a;
    else if (!a.vld) r = b;
    else r = ($signed(a.val) <= $signed(b.val)) ? a : b;
    return r;
  endfunction

  function automatic ent_t pick_max(ent_t a, ent_t b);
    ent_t r;
    if (!b.vld) r = a;
    else if (!a.vld) r = b;
    else r = ($signed(a.val) >= $signed(b.val)) ? a : b;
    return r;
  endfunction

  function automatic ent_t min_of(node_t n);
    ent_t r;
    r.val = n.mnv;
    r.pos = n.mnp;
    r.vld = n.vld;
    return r;
  endfunction

  function automatic ent_t max_of(node_t n);
    ent_t r;
    r.val = n.mxv;
    r.pos = n.mxp;
    r.vld = n.vld;
    return r;
  endfunction

endpackage

@@ design/rmmit_in_if.sv @@
interface rmmit_in_if;
  import rmmit_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              operation;
  logic [IDX_W-1:0]        first_index;
  logic [IDX_W-1:0]        second_index;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, operation, first_index, second_index, value, input ready);
  modport sink (input valid, operation, first_index, second_index, value, output ready);
endinterface

@@ design/rmmit_out_if.sv @@
interface rmmit_out_if;
  import rmmit_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    found;
  logic signed [VAL_W-1:0] min_value;
  logic [IDX_W-1:0]        min_position;
  logic signed [VAL_W-1:0] max_value;
  logic [IDX_W-1:0]        max_position;
  logic                    ignored;

  modport source (output valid, found, min_value, min_position, max_value, max_position,
                  ignored, input ready);
  modport sink (input valid, found, min_value, min_position, max_value, max_position,
                ignored, output ready);
endinterface

@@ design/rmmit_dp.sv @@
module rmmit_dp import rmmit_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CNT_W-1:0]        cfg_data_i,
  input  logic [1:0]              operation_i,
  input  logic [IDX_W-1:0]        first_index_i,
  input  logic [IDX_W-1:0]        second_index_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  output res_t                    res_o
);

  node_t mem [NODE_COUNT];
  node_t rda_q, rdb_q;

  logic [CNT_W-1:0]        n_q;
  logic [NODE_W:0]         clr_cnt_q;
  logic                    second_q;
  op_e                     op_q;
  logic [IDX_W-1:0]        a_q, b_q;
  logic [NODE_W-1:0]       k_q;
  logic signed [VAL_W-1:0] leaf_val_q, st_val_q;
  logic [IDX_W-1:0]        leaf_pos_q;
  logic                    leaf_vld_q, st_vld_q;
  logic [SPAN_W-1:0]       lo_q, hi_q;
  ent_t                    lmin_q, lmax_q, rmin_q, rmax_q;
  res_t                    res_q;

  logic [CNT_W-1:0]  n_eff;
  logic [IDX_W-1:0]  last, hi_end;
  logic [NODE_W-1:0] addr_a, addr_b, waddr;
  logic              we;
  node_t             wdata, comb;
  logic [SPAN_W-1:0] lo_nx, hi_nx, hi_m1;
  ent_t              fmin, fmax;
  res_t              res_d;

  always_comb begin
    if (n_q == '0) n_eff = CNT_W'(1);
    else if (n_q > CNT_W'(MAX_ELEMENTS)) n_eff = CNT_W'(MAX_ELEMENTS);
    else n_eff = n_q;
  end

  assign last   = IDX_W'(n_eff - CNT_W'(1));
  assign hi_end = (b_q < last) ? b_q : last;
  assign hi_m1  = hi_q - SPAN_W'(1);
  assign lo_nx  = (lo_q + SPAN_W'(lo_q[0])) >> 1;
  assign hi_nx  = (hi_q - SPAN_W'(hi_q[0])) >> 1;

  assign sts_o.clr_busy  = ~clr_cnt_q[NODE_W];
  assign sts_o.op        = op_q;
  assign sts_o.bad_write = {1'b0, a_q} >= n_eff;
  assign sts_o.bad_swap  = (a_q == b_q) || ({1'b0, a_q} >= n_eff) || ({1'b0, b_q} >= n_eff);
  assign sts_o.q_empty   = a_q > hi_end;
  assign sts_o.k_root    = k_q == NODE_W'(1);
  assign sts_o.second    = second_q;
  assign sts_o.q_more    = lo_nx < hi_nx;

  always_comb begin
    comb.mnv = pick_min(min_of(rda_q), min_of(rdb_q)).val;
    comb.mnp = pick_min(min_of(rda_q), min_of(rdb_q)).pos;
    comb.mxv = pick_max(max_of(rda_q), max_of(rdb_q)).val;
    comb.mxp = pick_max(max_of(rda_q), max_of(rdb_q)).pos;
    comb.vld = rda_q.vld | rdb_q.vld;
  end

  always_comb begin
    addr_a = lo_q[NODE_W-1:0];
    addr_b = hi_m1[NODE_W-1:0];
    if (cmd_i.up_rd) begin
      addr_a = {k_q[NODE_W-2:0], 1'b0};
      addr_b = {k_q[NODE_W-2:0], 1'b1};
    end else if (cmd_i.sw_rd || cmd_i.rd_rd) begin
      addr_a = {1'b1, a_q};
      addr_b = {1'b1, b_q};
    end
    we    = cmd_i.clr | cmd_i.leaf_wr | cmd_i.up_wr;
    waddr = k_q;
    wdata = comb;
    if (cmd_i.clr) begin
      waddr = clr_cnt_q[NODE_W-1:0];
      wdata = '0;
    end else if (cmd_i.leaf_wr) begin
      wdata = {leaf_val_q, leaf_pos_q, leaf_val_q, leaf_pos_q, leaf_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rda_q <= mem[addr_a];
    rdb_q <= mem[addr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q       <= CNT_W'(MAX_ELEMENTS);
      clr_cnt_q <= '0;
      second_q  <= 1'b0;
    end else begin
      if (cfg_we_i) n_q <= cfg_data_i;
      if (cmd_i.clr) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cmd_i.sw_cap) second_q <= 1'b1;
      else if (cmd_i.sw_next) second_q <= 1'b0;
    end
  end

  always_comb begin
    fmin  = pick_min(lmin_q, rmin_q);
    fmax  = pick_max(lmax_q, rmax_q);
    res_d = '0;
    case (op_q)
      OP_WRITE: res_d.ignored = sts_o.bad_write;
      OP_READ: begin
        res_d.min_value    = lmin_q.val;
        res_d.min_position = lmin_q.pos;
      end
      OP_SWAP: res_d.ignored = sts_o.bad_swap;
      OP_QUERY: begin
        if (!sts_o.q_empty && fmin.vld) begin
          res_d.found        = 1'b1;
          res_d.min_value    = fmin.val;
          res_d.min_position = fmin.pos;
          res_d.max_value    = fmax.val;
          res_d.max_position = fmax.pos;
        end
      end
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q       <= op_e'(operation_i);
      a_q        <= first_index_i;
      b_q        <= second_index_i;
      k_q        <= {1'b1, first_index_i};
      leaf_val_q <= value_i;
      leaf_pos_q <= first_index_i;
      leaf_vld_q <= 1'b1;
    end
    if (cmd_i.leaf_wr || cmd_i.up_wr) k_q <= k_q >> 1;
    if (cmd_i.sw_cap) begin
      leaf_val_q <= rdb_q.mnv;
      leaf_vld_q <= rdb_q.vld;
      leaf_pos_q <= a_q;
      k_q        <= {1'b1, a_q};
      st_val_q   <= rda_q.mnv;
      st_vld_q   <= rda_q.vld;
    end
    if (cmd_i.sw_next) begin
      leaf_val_q <= st_val_q;
      leaf_vld_q <= st_vld_q;
      leaf_pos_q <= b_q;
      k_q        <= {1'b1, b_q};
    end
    if (cmd_i.rd_cap) begin
      lmin_q.val <= rda_q.mnv;
      lmin_q.pos <= a_q;
      lmin_q.vld <= 1'b1;
    end
    if (cmd_i.q_init) begin
      lo_q   <= {2'b01, a_q};
      hi_q   <= {2'b01, hi_end} + SPAN_W'(1);
      lmin_q <= '0;
      lmax_q <= '0;
      rmin_q <= '0;
      rmax_q <= '0;
    end
    if (cmd_i.q_cmb) begin
      if (lo_q[0]) begin
        lmin_q <= pick_min(lmin_q, min_of(rda_q));
        lmax_q <= pick_max(lmax_q, max_of(rda_q));
      end
      if (hi_q[0]) begin
        rmin_q <= pick_min(min_of(rdb_q), rmin_q);
        rmax_q <= pick_max(max_of(rdb_q), rmax_q);
      end
      lo_q <= lo_nx;
      hi_q <= hi_nx;
    end
    if (cmd_i.fin) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

@@ design/rmmit_ctrl.sv @@
module rmmit_ctrl import rmmit_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic out_ready_i,
  output logic out_valid_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_free;

  assign out_free    = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.fin) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_busy) cmd_o.clr = 1'b1;
        else state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts_i.op)
          OP_WRITE: state_d = sts_i.bad_write ? ST_FINISH : ST_LEAF_WR;
          OP_READ:  state_d = ST_RD_RD;
          OP_SWAP:  state_d = sts_i.bad_swap ? ST_FINISH : ST_SW_RD;
          OP_QUERY: begin
            cmd_o.q_init = ~sts_i.q_empty;
            state_d      = sts_i.q_empty ? ST_FINISH : ST_Q_RD;
          end
          default: state_d = ST_FINISH;
        endcase
      end
      ST_LEAF_WR: begin
        cmd_o.leaf_wr = 1'b1;
        state_d       = ST_UP_RD;
      end
      ST_UP_RD: begin
        cmd_o.up_rd = 1'b1;
        state_d     = ST_UP_WR;
      end
      ST_UP_WR: begin
        cmd_o.up_wr = 1'b1;
        if (!sts_i.k_root) state_d = ST_UP_RD;
        else if (sts_i.second) state_d = ST_SW_NEXT;
        else state_d = ST_FINISH;
      end
      ST_SW_RD: begin
        cmd_o.sw_rd = 1'b1;
        state_d     = ST_SW_CAP;
      end
      ST_SW_CAP: begin
        cmd_o.sw_cap = 1'b1;
        state_d      = ST_LEAF_WR;
      end
      ST_SW_NEXT: begin
        cmd_o.sw_next = 1'b1;
        state_d       = ST_LEAF_WR;
      end
      ST_RD_RD: begin
        cmd_o.rd_rd = 1'b1;
        state_d     = ST_RD_CAP;
      end
      ST_RD_CAP: begin
        cmd_o.rd_cap = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_Q_RD: begin
        cmd_o.q_rd = 1'b1;
        state_d    = ST_Q_CMB;
      end
      ST_Q_CMB: begin
        cmd_o.q_cmb = 1'b1;
        state_d     = sts_i.q_more ? ST_Q_RD : ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ design/range_min_max_index_tree.sv @@
// Channel  Dir  Word
// in_i     in   operation, first_index, second_index, value
// out_o    out  found, min_value, min_position, max_value, max_position, ignored
// cfg      in   cfg_we_i, cfg_data_i (element_count)
//
// One word is worked at a time through a single two-read, one-write node memory.
// A read fetches one leaf; a write updates the leaf and each parent up to the root;
// a swap does two such writes; a query combines nodes level by level toward the root.
// After reset the node memory is cleared one entry a cycle, all 2048 entries, with in_i not ready.
// A finished result waits in the output register; a new word is taken meanwhile.
module range_min_max_index_tree import rmmit_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_data_i,
  rmmit_in_if.sink         in_i,
  rmmit_out_if.source      out_o
);

  cmd_t cmd;
  sts_t sts;
  res_t res;

  rmmit_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rmmit_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .operation_i    (in_i.operation),
    .first_index_i  (in_i.first_index),
    .second_index_i (in_i.second_index),
    .value_i        (in_i.value),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .res_o          (res)
  );

  assign out_o.found        = res.found;
  assign out_o.min_value    = res.min_value;
  assign out_o.min_position = res.min_position;
  assign out_o.max_value    = res.max_value;
  assign out_o.max_position = res.max_position;
  assign out_o.ignored      = res.ignored;

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.clr_busy |-> !in_i.ready)
    else $error("word accepted during node clear");

  a_rise_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.fin))
    else $error("result shown without finish");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fin |-> (!out_o.valid || out_o.ready))
    else $error("pending result overwritten");

endmodule
